[sv/bmap_pkg.sv]
// Shared types and constants for the bank mapper with audio registers and line IRQ.
// Used by bmap_ctrl, bmap_dp and the top level; depends on nothing.
package bmap_pkg;

    localparam int NUM_CHANNELS_DEF = 6;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = 3;

    // configuration register indexes (paddr[2])
    localparam logic REG_PRG_BANK_COUNT = 1'b0;
    localparam logic REG_CHR_BANK_MASK  = 1'b1;

    localparam logic [8:0] PRG_BANK_COUNT_RST = 9'd64;
    localparam logic [7:0] CHR_BANK_MASK_RST  = 8'hff;

    // write decode groups
    localparam logic [3:0] GRP_PRG0      = 4'd0;
    localparam logic [3:0] GRP_PRG2      = 4'd2;
    localparam logic [3:0] GRP_AUDIO     = 4'd3;
    localparam logic [3:0] GRP_CHR0      = 4'd4;
    localparam logic [3:0] GRP_CHR7      = 4'd11;
    localparam logic [3:0] GRP_MIRROR    = 4'd12;
    localparam logic [3:0] GRP_IRQ_LATCH = 4'd13;
    localparam logic [3:0] GRP_IRQ_CTRL  = 4'd14;
    localparam logic [3:0] GRP_IRQ_ACK   = 4'd15;

    // audio select groups (upper nibble)
    localparam logic [3:0] AUD_GRP_KEY = 4'h2;
    localparam logic [7:0] AUD_PATCH_END = 8'h08;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [7:0] IRQ_COUNT_MAX = 8'hff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ISSUE
    } bmap_state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic issue;
    } bmap_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } bmap_status_t;

endpackage

[sv/bank_mapper_audio_regs_line_irq.sv]
// Top level of the cartridge bank mapper with audio key registers and line IRQ.
// Instantiates bmap_ctrl and bmap_dp; depends on bmap_pkg.
//
// Each input word is a CPU bus write (tuser 0) or a scanline tick (tuser 1) and yields
// exactly one result word. Ticks and most writes pass from acceptance to the ISSUE state,
// which loads the result register once it is free; the block then goes idle for the next word.
// A program bank write passes through the DIVIDE state first, since its bank number is
// reduced modulo the bank count by a bit-serial remainder unit, one dividend bit a cycle.
// One word is in work at a time. A new word is taken while a finished result still waits
// in the output register, but its own result is held back until that register is free.
// Bank count and character mask are written over the APB port at byte addresses 0 and 4;
// the user must write them only while the block is idle, as the block does not enforce it.
module bank_mapper_audio_regs_line_irq
#(
    parameter int NUM_CHANNELS = bmap_pkg::NUM_CHANNELS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bmap_pkg::IN_DATA_W-1:0]      s_tdata,  // address[15:0], value[23:16]
    input  logic                                s_tuser,  // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // irq_line[0], mirroring[2:1], sound_enabled[3], prg_update[4], prg_slot[6:5],
    // prg_bank[14:7], chr_update[15], chr_slot[18:16], chr_bank[26:19],
    // key_changed[27], key_channel[30:28]
    output logic [bmap_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bmap_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bmap_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bmap_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    bmap_pkg::bmap_cmd_t    cmd;
    bmap_pkg::bmap_status_t status;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    bmap_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmap_dp
    #(
        .NUM_CHANNELS (NUM_CHANNELS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_write (cfg_write),
        .cfg_index (paddr[2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[sv/bmap_ctrl.sv]
// Sequencer for the bank mapper: input handshake, remainder step count, result issue.
// Depends on bmap_pkg.
module bmap_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  bmap_pkg::bmap_status_t status,
    output bmap_pkg::bmap_cmd_t    cmd
);

    bmap_pkg::bmap_state_t state_reg;
    bmap_pkg::bmap_state_t state_next;
    logic [bmap_pkg::STEP_W-1:0] step_reg;
    logic [bmap_pkg::STEP_W-1:0] step_next;
    logic                        last_step;

    assign last_step = (step_reg == bmap_pkg::STEP_W'(bmap_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            bmap_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    state_next = status.need_div ? bmap_pkg::ST_DIVIDE : bmap_pkg::ST_ISSUE;
                end
            end
            bmap_pkg::ST_DIVIDE:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = bmap_pkg::ST_ISSUE;
                end
            end
            bmap_pkg::ST_ISSUE:
            begin
                if (status.out_free)
                begin
                    state_next = bmap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmap_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.issue    = 1'b0;
        unique case (state_reg)
            bmap_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            bmap_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            bmap_pkg::ST_ISSUE:
            begin
                cmd.issue = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmap_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

[sv/bmap_dp.sv]
// Datapath of the bank mapper: configuration registers, write decode, IRQ counter,
// key bits, bit-serial remainder unit and output register. Depends on bmap_pkg.
module bmap_dp
#(
    parameter int NUM_CHANNELS = bmap_pkg::NUM_CHANNELS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bmap_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bmap_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [bmap_pkg::APB_DATA_W-1:0]     cfg_wdata,
    output logic [bmap_pkg::APB_DATA_W-1:0]     cfg_rdata,
    input  bmap_pkg::bmap_cmd_t                 cmd,
    output bmap_pkg::bmap_status_t              status
);

    logic [8:0] prg_bank_count_reg;
    logic [7:0] chr_bank_mask_reg;

    logic [1:0]              mirror_reg,      mirror_next;
    logic                    sound_reg,       sound_next;
    logic [7:0]              audio_sel_reg,   audio_sel_next;
    logic [NUM_CHANNELS-1:0] chan_key_reg,    chan_key_next;
    logic [7:0]              irq_latch_reg,   irq_latch_next;
    logic                    irq_ctrl_arm_reg, irq_ctrl_arm_next;
    logic [7:0]              irq_count_reg,   irq_count_next;
    logic                    irq_armed_reg,   irq_armed_next;
    logic                    irq_pending_reg, irq_pending_next;

    // result of the item in flight
    logic       res_prg_upd_reg,  res_prg_upd_next;
    logic [1:0] res_prg_slot_reg, res_prg_slot_next;
    logic       res_chr_upd_reg,  res_chr_upd_next;
    logic [2:0] res_chr_slot_reg, res_chr_slot_next;
    logic [7:0] res_chr_bank_reg, res_chr_bank_next;
    logic       res_key_reg,      res_key_next;
    logic [2:0] res_key_chan_reg, res_key_chan_next;

    // remainder unit
    logic [8:0] rem_reg;
    logic [8:0] rem_next;
    logic [7:0] quo_reg;
    logic [7:0] quo_next;
    logic [9:0] rem_shift;

    logic                                m_tvalid_reg;
    logic [bmap_pkg::OUT_DATA_W-1:0]     m_tdata_reg;
    logic [bmap_pkg::OUT_DATA_W-1:0]     m_tdata_next;

    logic [15:0] in_addr;
    logic [7:0]  in_value;
    logic [3:0]  grp;
    logic [3:0]  chr_idx;
    logic [3:0]  aud_chan;
    logic [3:0]  aud_grp;
    logic [7:0]  prg_bank_out;

    assign in_addr  = s_tdata[15:0];
    assign in_value = s_tdata[23:16];
    assign grp      = {in_addr[14:12], in_addr[4] | in_addr[3]};
    assign chr_idx  = grp - bmap_pkg::GRP_CHR0;
    assign aud_chan = audio_sel_reg[3:0];
    assign aud_grp  = audio_sel_reg[7:4];

    assign status.need_div = (s_tuser == bmap_pkg::MODE_WRITE) && (grp <= bmap_pkg::GRP_PRG2);
    assign status.out_free = !m_tvalid_reg || m_tready;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg <= bmap_pkg::PRG_BANK_COUNT_RST;
            chr_bank_mask_reg  <= bmap_pkg::CHR_BANK_MASK_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == bmap_pkg::REG_PRG_BANK_COUNT)
            begin
                prg_bank_count_reg <= cfg_wdata[8:0];
            end
            else
            begin
                chr_bank_mask_reg <= cfg_wdata[7:0];
            end
        end
    end

    always_comb
    begin
        if (cfg_index == bmap_pkg::REG_PRG_BANK_COUNT)
        begin
            cfg_rdata = bmap_pkg::APB_DATA_W'(prg_bank_count_reg);
        end
        else
        begin
            cfg_rdata = bmap_pkg::APB_DATA_W'(chr_bank_mask_reg);
        end
    end

    // decode of one accepted word
    always_comb
    begin
        mirror_next       = mirror_reg;
        sound_next        = sound_reg;
        audio_sel_next    = audio_sel_reg;
        chan_key_next     = chan_key_reg;
        irq_latch_next    = irq_latch_reg;
        irq_ctrl_arm_next = irq_ctrl_arm_reg;
        irq_count_next    = irq_count_reg;
        irq_armed_next    = irq_armed_reg;
        irq_pending_next  = irq_pending_reg;
        res_prg_upd_next  = res_prg_upd_reg;
        res_prg_slot_next = res_prg_slot_reg;
        res_chr_upd_next  = res_chr_upd_reg;
        res_chr_slot_next = res_chr_slot_reg;
        res_chr_bank_next = res_chr_bank_reg;
        res_key_next      = res_key_reg;
        res_key_chan_next = res_key_chan_reg;

        if (cmd.accept)
        begin
            res_prg_upd_next  = 1'b0;
            res_prg_slot_next = '0;
            res_chr_upd_next  = 1'b0;
            res_chr_slot_next = '0;
            res_chr_bank_next = '0;
            res_key_next      = 1'b0;
            res_key_chan_next = '0;

            if (s_tuser == bmap_pkg::MODE_TICK)
            begin
                if (irq_armed_reg)
                begin
                    if (irq_count_reg == bmap_pkg::IRQ_COUNT_MAX)
                    begin
                        irq_count_next   = irq_latch_reg;
                        irq_pending_next = 1'b1;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg + 8'd1;
                    end
                end
            end
            else
            begin
                unique case (grp) inside
                    [bmap_pkg::GRP_PRG0:bmap_pkg::GRP_PRG2]:
                    begin
                        res_prg_upd_next  = 1'b1;
                        res_prg_slot_next = grp[1:0];
                    end
                    bmap_pkg::GRP_AUDIO:
                    begin
                        if (!in_addr[5])
                        begin
                            audio_sel_next = in_value;
                        end
                        else if (audio_sel_reg >= bmap_pkg::AUD_PATCH_END
                                 && aud_grp == bmap_pkg::AUD_GRP_KEY)
                        begin
                            // only the key bits are visible; other audio state is not kept
                            for (int i = 0; i < NUM_CHANNELS; i++)
                            begin
                                if (aud_chan == 4'(i))
                                begin
                                    if (in_value[4] != chan_key_reg[i])
                                    begin
                                        res_key_next      = 1'b1;
                                        res_key_chan_next = aud_chan[2:0];
                                    end
                                    chan_key_next[i] = in_value[4];
                                end
                            end
                        end
                    end
                    [bmap_pkg::GRP_CHR0:bmap_pkg::GRP_CHR7]:
                    begin
                        res_chr_upd_next  = 1'b1;
                        res_chr_slot_next = chr_idx[2:0];
                        res_chr_bank_next = in_value & chr_bank_mask_reg;
                    end
                    bmap_pkg::GRP_MIRROR:
                    begin
                        mirror_next = in_value[1:0];
                        sound_next  = !in_value[6];
                    end
                    bmap_pkg::GRP_IRQ_LATCH:
                    begin
                        irq_latch_next = in_value;
                    end
                    bmap_pkg::GRP_IRQ_CTRL:
                    begin
                        irq_ctrl_arm_next = in_value[0];
                        irq_armed_next    = in_value[1];
                        if (in_value[1])
                        begin
                            irq_count_next = irq_latch_reg;
                        end
                        irq_pending_next = 1'b0;
                    end
                    default:
                    begin
                        // acknowledge
                        irq_armed_next   = irq_ctrl_arm_reg;
                        irq_pending_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // restoring remainder, one dividend bit a step; a zero or oversize count leaves the value
    assign rem_shift = {rem_reg, quo_reg[7]};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.accept)
        begin
            rem_next = '0;
            quo_next = in_value;
        end
        else if (cmd.div_step)
        begin
            quo_next = {quo_reg[6:0], 1'b0};
            if (rem_shift >= {1'b0, prg_bank_count_reg})
            begin
                rem_next = 9'(rem_shift - {1'b0, prg_bank_count_reg});
            end
            else
            begin
                rem_next = rem_shift[8:0];
            end
        end
    end

    assign prg_bank_out = res_prg_upd_reg ? rem_reg[7:0] : 8'd0;

    always_comb
    begin
        m_tdata_next        = '0;
        m_tdata_next[0]     = irq_pending_reg;
        m_tdata_next[2:1]   = mirror_reg;
        m_tdata_next[3]     = sound_reg;
        m_tdata_next[4]     = res_prg_upd_reg;
        m_tdata_next[6:5]   = res_prg_slot_reg;
        m_tdata_next[14:7]  = prg_bank_out;
        m_tdata_next[15]    = res_chr_upd_reg;
        m_tdata_next[18:16] = res_chr_slot_reg;
        m_tdata_next[26:19] = res_chr_bank_reg;
        m_tdata_next[27]    = res_key_reg;
        m_tdata_next[30:28] = res_key_chan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg       <= '0;
            sound_reg        <= 1'b1;
            audio_sel_reg    <= '0;
            chan_key_reg     <= '0;
            irq_latch_reg    <= '0;
            irq_ctrl_arm_reg <= 1'b0;
            irq_count_reg    <= '0;
            irq_armed_reg    <= 1'b0;
            irq_pending_reg  <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            mirror_reg       <= mirror_next;
            sound_reg        <= sound_next;
            audio_sel_reg    <= audio_sel_next;
            chan_key_reg     <= chan_key_next;
            irq_latch_reg    <= irq_latch_next;
            irq_ctrl_arm_reg <= irq_ctrl_arm_next;
            irq_count_reg    <= irq_count_next;
            irq_armed_reg    <= irq_armed_next;
            irq_pending_reg  <= irq_pending_next;
            if (cmd.issue)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_prg_upd_reg  <= res_prg_upd_next;
        res_prg_slot_reg <= res_prg_slot_next;
        res_chr_upd_reg  <= res_chr_upd_next;
        res_chr_slot_reg <= res_chr_slot_next;
        res_chr_bank_reg <= res_chr_bank_next;
        res_key_reg      <= res_key_next;
        res_key_chan_reg <= res_key_chan_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        if (cmd.issue)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[tb/tb_bank_mapper_audio_regs_line_irq.sv]
// Testbench for bank_mapper_audio_regs_line_irq: directed table, then random bus writes and
// scanline ticks under several bank count / character mask settings, checked by a predictor.
// Depends on bmap_pkg and the block's top level.
`timescale 1ns / 100ps

module tb_bank_mapper_audio_regs_line_irq;

    import bmap_pkg::*;

    localparam int NUM_CH       = NUM_CHANNELS_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 72;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [3:0] AUD_GRP_FREQ = 4'h1;
    localparam logic [3:0] AUD_GRP_VOL  = 4'h3;

    typedef struct packed {
        logic [2:0] key_channel;
        logic       key_changed;
        logic [7:0] chr_bank;
        logic [2:0] chr_slot;
        logic       chr_update;
        logic [7:0] prg_bank;
        logic [1:0] prg_slot;
        logic       prg_update;
        logic       sound_enabled;
        logic [1:0] mirroring;
        logic       irq_line;
    } map_result_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] addr;
        logic [7:0]  val;
        logic        typed;
        map_result_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;   // address[15:0], value[23:16]
    logic s_tuser = 1'b0;                  // mode
    logic m_tvalid;
    logic m_tready = 1'b0;
    // irq_line[0], mirroring[2:1], sound_enabled[3], prg_update[4], prg_slot[6:5],
    // prg_bank[14:7], chr_update[15], chr_slot[18:16], chr_bank[26:19],
    // key_changed[27], key_channel[30:28]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // mapper image kept by the predictor
    logic [8:0] bank_count_r = PRG_BANK_COUNT_RST;
    logic [7:0] chr_mask_r   = CHR_BANK_MASK_RST;
    logic [7:0] prg_r [3];
    logic [7:0] chr_r [8];
    logic [1:0] mirror_r  = 2'd0;
    logic       sound_r   = 1'b1;
    logic [7:0] aud_sel_r = 8'd0;
    logic [7:0] patch_r [8];
    logic [8:0] freq_r [NUM_CH];
    logic [2:0] octave_r [NUM_CH];
    logic       sustain_r [NUM_CH];
    logic       key_r [NUM_CH];
    logic [3:0] volume_r [NUM_CH];
    logic [3:0] instr_r [NUM_CH];
    logic [7:0] irq_latch_r = 8'd0;
    logic [7:0] irq_ctrl_r  = 8'd0;
    logic [7:0] irq_count_r = 8'd0;
    logic       irq_armed_r = 1'b0;
    logic       irq_pending_r = 1'b0;

    map_result_t result_q [$];
    script_row_t script [$];

    int send_idle_pct  = 22;
    int recv_stall_pct = 86;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    int unsigned phase_count [9] = '{1, 256, 0, 37, 300, 511, 3, 200, 64};
    logic [7:0]  phase_mask  [9] = '{8'h00, 8'hff, 8'h0f, 8'ha5, 8'h3f, 8'h80, 8'h5c, 8'h01, 8'hff};

    bank_mapper_audio_regs_line_irq dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one word to the mapper image and return the result it should produce.
    function automatic map_result_t predict_word(logic mode, logic [15:0] a, logic [7:0] v);
        map_result_t r;
        logic [3:0]  g;
        logic [3:0]  sel_grp;
        int          c;
        int          b;
        logic [2:0]  s;
        r = '0;
        if (mode == MODE_TICK)
        begin
            if (irq_armed_r)
            begin
                if (irq_count_r == IRQ_COUNT_MAX)
                begin
                    irq_count_r   = irq_latch_r;
                    irq_pending_r = 1'b1;
                end
                else
                    irq_count_r = irq_count_r + 8'd1;
            end
        end
        else
        begin
            // bit 15 is not decoded
            g = {a[14:12], a[4] | a[3]};
            if (g <= GRP_PRG2)
            begin
                b = v;
                if (bank_count_r != 9'd0)
                    b = b % int'(bank_count_r);
                prg_r[g[1:0]] = b[7:0];
                r.prg_update = 1'b1;
                r.prg_slot   = g[1:0];
                r.prg_bank   = b[7:0];
            end
            else if (g == GRP_AUDIO)
            begin
                if (!a[5])
                    aud_sel_r = v;
                else
                begin
                    c = aud_sel_r[3:0];
                    sel_grp = aud_sel_r[7:4];
                    if (aud_sel_r < AUD_PATCH_END)
                        patch_r[aud_sel_r[2:0]] = v;
                    else if (c < NUM_CH)
                    begin
                        if (sel_grp == AUD_GRP_FREQ)
                            freq_r[c][7:0] = v;
                        else if (sel_grp == AUD_GRP_KEY)
                        begin
                            freq_r[c][8] = v[0];
                            octave_r[c]  = v[3:1];
                            sustain_r[c] = v[5];
                            if (v[4] != key_r[c])
                            begin
                                r.key_changed = 1'b1;
                                r.key_channel = c[2:0];
                            end
                            key_r[c] = v[4];
                        end
                        else if (sel_grp == AUD_GRP_VOL)
                        begin
                            volume_r[c] = v[3:0];
                            instr_r[c]  = v[7:4];
                        end
                    end
                end
            end
            else if (g <= GRP_CHR7)
            begin
                s = 3'(g - GRP_CHR0);
                chr_r[s] = v & chr_mask_r;
                r.chr_update = 1'b1;
                r.chr_slot   = s;
                r.chr_bank   = chr_r[s];
            end
            else if (g == GRP_MIRROR)
            begin
                mirror_r = v[1:0];
                sound_r  = !v[6];
            end
            else if (g == GRP_IRQ_LATCH)
                irq_latch_r = v;
            else if (g == GRP_IRQ_CTRL)
            begin
                irq_ctrl_r  = v;
                irq_armed_r = v[1];
                if (irq_armed_r)
                    irq_count_r = irq_latch_r;
                irq_pending_r = 1'b0;
            end
            else
            begin
                irq_armed_r   = irq_ctrl_r[0];
                irq_pending_r = 1'b0;
            end
        end
        r.irq_line      = irq_pending_r;
        r.mirroring     = mirror_r;
        r.sound_enabled = sound_r;
        return r;
    endfunction

    function automatic map_result_t status_word(logic irq, logic [1:0] mir, logic snd,
                                                logic pu, logic [1:0] ps, logic [7:0] pb);
        map_result_t r;
        r = '0;
        r.irq_line      = irq;
        r.mirroring     = mir;
        r.sound_enabled = snd;
        r.prg_update    = pu;
        r.prg_slot      = ps;
        r.prg_bank      = pb;
        return r;
    endfunction

    function automatic script_row_t step_row(logic mode, logic [15:0] a, logic [7:0] v,
                                             logic typed, map_result_t want);
        script_row_t r;
        r.mode  = mode;
        r.addr  = a;
        r.val   = v;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Offer one word, hold it until taken, then queue its expected result.
    task automatic send_item(logic mode, logic [15:0] a, logic [7:0] v,
                             logic typed, map_result_t want);
        map_result_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {v, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_word(mode, a, v);
        result_q.push_back(typed ? want : pred);
    endtask

    task automatic send_random();
        int          pick;
        logic [3:0]  g;
        logic [15:0] a;
        logic [7:0]  v;
        logic        mode;
        pick = $urandom_range(99);
        mode = MODE_WRITE;
        a = 16'($urandom);
        v = 8'($urandom);
        g = GRP_IRQ_ACK;
        if (pick < 30)
            mode = MODE_TICK;
        else if (pick < 44)
            g = GRP_PRG0 + 4'($urandom_range(2));
        else if (pick < 58)
            g = GRP_CHR0 + 4'($urandom_range(7));
        else if (pick < 80)
            g = GRP_AUDIO;
        else if (pick < 84)
            g = GRP_MIRROR;
        else if (pick < 89)
        begin
            // keep the latch high mostly so the counter wraps within a few ticks
            g = GRP_IRQ_LATCH;
            if ($urandom_range(3) != 0)
                v[7:4] = 4'hf;
        end
        else if (pick < 95)
        begin
            g = GRP_IRQ_CTRL;
            if ($urandom_range(3) != 0)
                v[1] = 1'b1;
        end
        if (mode == MODE_WRITE)
        begin
            a[14:12] = g[3:1];
            a[4:3] = g[0] ? 2'($urandom_range(3, 1)) : 2'b00;
            if (g == GRP_AUDIO)
            begin
                a[5] = ($urandom_range(2) != 0);
                // selects mostly land on a real patch byte or channel register
                if (!a[5] && $urandom_range(4) != 0)
                    v = {4'($urandom_range(3)), 4'($urandom_range(7))};
            end
        end
        send_item(mode, a, v, 1'b0, '0);
    endtask

    // Drop valid and wait until the block has drained every outstanding word.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PRG_BANK_COUNT)
            bank_count_r = data[8:0];
        else
            chr_mask_r = data[7:0];
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        map_result_t got;
        map_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = map_result_t'(m_tdata[30:0]);
            if (result_q.size() == 0)
            begin
                $error("result word %h with nothing expected", m_tdata);
                mismatches++;
            end
            else
            begin
                want = result_q.pop_front();
                check_field("irq_line", want.irq_line, got.irq_line);
                check_field("mirroring", want.mirroring, got.mirroring);
                check_field("sound_enabled", want.sound_enabled, got.sound_enabled);
                check_field("prg_update", want.prg_update, got.prg_update);
                check_field("prg_slot", want.prg_slot, got.prg_slot);
                check_field("prg_bank", want.prg_bank, got.prg_bank);
                check_field("chr_update", want.chr_update, got.chr_update);
                check_field("chr_slot", want.chr_slot, got.chr_slot);
                check_field("chr_bank", want.chr_bank, got.chr_bank);
                check_field("key_changed", want.key_changed, got.key_changed);
                check_field("key_channel", want.key_channel, got.key_channel);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            chr_r[i]   = 8'(i);
            patch_r[i] = 8'd0;
        end
        for (int i = 0; i < 3; i++)
            prg_r[i] = 8'd0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            freq_r[i]    = 9'd0;
            octave_r[i]  = 3'd0;
            sustain_r[i] = 1'b0;
            key_r[i]     = 1'b0;
            volume_r[i]  = 4'd0;
            instr_r[i]   = 4'd0;
        end

        script.push_back(step_row(MODE_TICK, 16'hffff, 8'hff, 1'b1, status_word(0, 0, 1, 0, 0, 0)));
        script.push_back(step_row(MODE_WRITE, 16'h8000, 8'hff, 1'b1,
                                  status_word(0, 0, 1, 1, 0, 8'd63)));
        script.push_back(step_row(MODE_WRITE, 16'h8008, 8'h00, 1'b1,
                                  status_word(0, 0, 1, 1, 1, 8'd0)));
        script.push_back(step_row(MODE_WRITE, 16'h9000, 8'h80, 1'b0, '0));
        // key on through the audio select / data pair, including a dead channel
        script.push_back(step_row(MODE_WRITE, 16'h9010, 8'h20, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9030, 8'h10, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9030, 8'h10, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9010, 8'h25, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9028, 8'hff, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9010, 8'h26, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9030, 8'hff, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9018, 8'h07, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'h9030, 8'haa, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'ha000, 8'hff, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'hd008, 8'h80, 1'b0, '0));
        // low half aliases the upper half
        script.push_back(step_row(MODE_WRITE, 16'h2008, 8'h33, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'he000, 8'h43, 1'b1, status_word(0, 3, 0, 0, 0, 0)));
        script.push_back(step_row(MODE_WRITE, 16'he000, 8'h02, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'he008, 8'hfe, 1'b0, '0));
        // arm with the cycle mode bit set; it must not change the counting
        script.push_back(step_row(MODE_WRITE, 16'hf000, 8'h07, 1'b0, '0));
        script.push_back(step_row(MODE_TICK, 16'h0000, 8'h00, 1'b0, '0));
        script.push_back(step_row(MODE_TICK, 16'h0000, 8'h00, 1'b1, status_word(1, 2, 1, 0, 0, 0)));
        script.push_back(step_row(MODE_TICK, 16'h5a5a, 8'h5a, 1'b0, '0));
        script.push_back(step_row(MODE_WRITE, 16'hf008, 8'h00, 1'b1, status_word(0, 2, 1, 0, 0, 0)));
        script.push_back(step_row(MODE_WRITE, 16'hf000, 8'h00, 1'b0, '0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].mode, script[i].addr, script[i].val, script[i].typed,
                      script[i].want);

        for (int p = 0; p < 9; p++)
        begin
            settle();
            apb_write(REG_PRG_BANK_COUNT, APB_DATA_W'(phase_count[p]));
            apb_write(REG_CHR_BANK_MASK, APB_DATA_W'(phase_mask[p]));
            if (p < 3)
            begin
                send_idle_pct  = 22;
                recv_stall_pct = 86;
            end
            else if (p < 6)
            begin
                send_idle_pct  = 86;
                recv_stall_pct = 22;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            repeat (PHASE_WORDS) send_random();
        end

        settle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
sv/bmap_pkg.sv
sv/bmap_ctrl.sv
sv/bmap_dp.sv
sv/bank_mapper_audio_regs_line_irq.sv
tb/tb_bank_mapper_audio_regs_line_irq.sv
